// ===== design/sjtcw_pkg.sv =====
package sjtcw_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [15:0] SPACE_CODE    = 16'h0020;
  localparam logic [15:0] QUESTION_CODE = 16'h003f;
  localparam logic [15:0] SECOND_HALF   = 16'h8000;
  localparam logic [7:0]  CH_LF = 8'h0a;
  localparam logic [7:0]  CH_CR = 8'h0d;
  localparam logic [7:0]  CH_BS = 8'h08;

  typedef struct packed {
    logic latch;
    logic plan;
    logic load_q;
    logic load_main;
    logic col0;
    logic bs;
    logic write1;
    logic write2;
    logic newline;
    logic cnt_clr;
    logic cnt_lastrow;
    logic scroll_rd;
    logic fill;
    logic setcur;
    logic rd_cell;
    logic drop_lead;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic pre_q;
    logic main_act;
    logic emit_lf;
    logic emit_cr;
    logic emit_bs;
    logic emit_pair;
    logic col_zero;
    logic wrap;
    logic row_last;
    logic cnt_copy_last;
    logic cnt_fill_last;
    logic out_free;
  } sts_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return b >= 8'h40 && b <= 8'hfc && b != 8'h7f;
  endfunction

  function automatic logic [15:0] jis_code(input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] jrow;
    logic [7:0] t;
    jrow = (lead <= 8'h9f) ? 8'((lead - 8'h71) << 1) + 8'd1 : 8'((lead - 8'hb1) << 1) + 8'd1;
    t = trail;
    if (t > 8'h7f) t = t - 8'd1;
    if (t >= 8'h9e) begin
      t = t - 8'h7d;
      jrow = jrow + 8'd1;
    end else begin
      t = t - 8'h1f;
    end
    return {t, 8'(jrow - 8'h20)};
  endfunction

endpackage

// ===== design/sjis_text_console_writer.sv =====
// Channel   Direction  Contents
// s_axis    in         tdata: op, byte_in, row, column; tlast: end_of_string
// m_axis    out        tdata: read_code, read_attribute, row_now, column_now;
//                      tuser: accepted
// apb       in         terminal_mode at 0x0, normal_attribute at 0x4
//
// Items are handled one at a time: a pair writes its second half in a further step, and
// a flushed lead byte or a wrap adds a further step each.
// A scroll walks the whole screen store through its one read and one write port,
// and clear screen writes every cell of the store with a space.
// After reset a clearing pass over every cell runs before the first input.
// The output register lets the next input transfer start while a result waits.
module sjis_text_console_writer
  import sjtcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], byte_in[9:2], row[14:10], column[21:15]
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_code[15:0], read_attribute[23:16],
                                      // row_now[28:24], column_now[35:29]
  output logic [0:0] m_axis_tuser,    // accepted[0]
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic terminal_mode;
  logic [7:0] normal_attribute;
  cmd_t cmd;
  sts_t sts;
  logic [15:0] read_code;
  logic [7:0] read_attribute;
  logic [4:0] row_now;
  logic [6:0] column_now;
  logic accepted;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, normal_attribute} : {31'd0, terminal_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= 1'b0;
      normal_attribute <= 8'd225;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) normal_attribute <= pwdata[7:0];
      else terminal_mode <= pwdata[0];
    end
  end

  sjtcw_ctrl #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .terminal_mode(terminal_mode),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts(sts),
    .cmd(cmd)
  );

  sjtcw_dp #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .normal_attribute(normal_attribute),
    .op(s_axis_tdata[1:0]),
    .byte_in(s_axis_tdata[9:2]),
    .end_of_string(s_axis_tlast),
    .row(s_axis_tdata[14:10]),
    .column(s_axis_tdata[21:15]),
    .cmd(cmd),
    .sts(sts),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .read_code(read_code),
    .read_attribute(read_attribute),
    .row_now(row_now),
    .column_now(column_now),
    .accepted(accepted)
  );

  assign m_axis_tdata = {4'd0, column_now, row_now, read_attribute, read_code};
  assign m_axis_tuser = accepted;

endmodule

// ===== design/sjtcw_ctrl.sv =====
module sjtcw_ctrl
  import sjtcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic terminal_mode,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int COPY_N = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_STEP0  = 4'd3;
  localparam logic [3:0] S_STEP1  = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_EMIT2  = 4'd6;
  localparam logic [3:0] S_SCROLL = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_FILL   = 4'd9;
  localparam logic [3:0] S_READ   = 4'd10;
  localparam logic [3:0] S_CLEAR  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state, state_next;
  logic second, second_next;
  logic ret_emit, ret_emit_next;
  logic [3:0] finish_state;
  logic [3:0] after_nl;

  assign in_ready = (state == S_IDLE);
  assign finish_state = second ? S_STEP1 : S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      second <= 1'b0;
      ret_emit <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
      ret_emit <= ret_emit_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    second_next = second;
    ret_emit_next = ret_emit;
    after_nl = finish_state;
    unique case (state)
      S_INIT: begin
        cmd.fill = 1'b1;
        if (sts.cnt_fill_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_BYTE: begin
            cmd.plan = 1'b1;
            state_next = S_STEP0;
          end
          OP_SET: begin
            cmd.setcur = 1'b1;
            state_next = S_DONE;
          end
          OP_READ: begin
            cmd.rd_cell = 1'b1;
            state_next = S_READ;
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            cmd.drop_lead = 1'b1;
            state_next = S_CLEAR;
          end
        endcase
      end
      S_STEP0: begin
        if (sts.pre_q) begin
          cmd.load_q = 1'b1;
          second_next = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_STEP1;
        end
      end
      S_STEP1: begin
        second_next = 1'b0;
        if (sts.main_act) begin
          cmd.load_main = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EMIT: begin
        if (sts.emit_cr) begin
          cmd.col0 = 1'b1;
          state_next = finish_state;
        end else if (sts.emit_bs) begin
          cmd.bs = !sts.col_zero;
          state_next = finish_state;
        end else if (sts.emit_lf || sts.wrap) begin
          cmd.newline = 1'b1;
          ret_emit_next = !sts.emit_lf;
          after_nl = sts.emit_lf ? finish_state : S_EMIT;
          if (sts.row_last && terminal_mode) begin
            if (COPY_N == 0) begin
              cmd.cnt_lastrow = 1'b1;
              state_next = S_FILL;
            end else begin
              cmd.cnt_clr = 1'b1;
              state_next = S_SCROLL;
            end
          end else begin
            state_next = after_nl;
          end
        end else begin
          cmd.write1 = 1'b1;
          state_next = sts.emit_pair ? S_EMIT2 : finish_state;
        end
      end
      S_EMIT2: begin
        cmd.write2 = 1'b1;
        state_next = finish_state;
      end
      S_SCROLL: begin
        cmd.scroll_rd = 1'b1;
        if (sts.cnt_copy_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.cnt_lastrow = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.cnt_fill_last) state_next = ret_emit ? S_EMIT : finish_state;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.fill = 1'b1;
        if (sts.cnt_fill_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/sjtcw_dp.sv =====
module sjtcw_dp
  import sjtcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] normal_attribute,
  input  logic [1:0] op,
  input  logic [7:0] byte_in,
  input  logic end_of_string,
  input  logic [4:0] row,
  input  logic [6:0] column,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] read_code,
  output logic [7:0] read_attribute,
  output logic [4:0] row_now,
  output logic [6:0] column_now,
  output logic accepted
);

  localparam int N = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int COPY_N = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] COPY_A = AW'(COPY_N);
  localparam logic [AW-1:0] COPY_LAST = AW'((COPY_N > 0) ? COPY_N - 1 : 0);
  localparam logic [AW-1:0] FILL_LAST = AW'(N - 1);
  localparam logic [6:0] COLS7 = 7'(SCREEN_COLUMNS);
  localparam logic [4:0] ROWS5 = 5'(SCREEN_ROWS);

  logic [23:0] mem [N];
  logic [23:0] rdata;

  logic [1:0] op_q;
  logic [7:0] b_q;
  logic last_q;
  logic [4:0] r_q;
  logic [6:0] c_q;
  logic [4:0] cur_row;
  logic [6:0] cur_col;
  logic lead_waiting;
  logic [7:0] pending_lead;
  logic pre_q, main_act, main_pair;
  logic [15:0] main_code;
  logic [15:0] emit_code;
  logic emit_pair;
  logic [AW-1:0] cnt;
  logic cp_v;
  logic [AW-1:0] cp_addr;
  logic ok_q;
  logic in_range;
  logic [AW-1:0] cur_addr, cell_addr;

  logic p_pre, p_act, p_pair, p_lw;
  logic [15:0] p_code;

  logic we;
  logic [AW-1:0] waddr;
  logic [23:0] wdata;
  logic re;
  logic [AW-1:0] raddr;

  assign in_range = (r_q < ROWS5) && (c_q < COLS7);
  assign cur_addr = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign cell_addr = AW'(r_q) * COLS_A + AW'(c_q);

  always_comb begin
    p_pre = 1'b0;
    p_act = 1'b0;
    p_pair = 1'b0;
    p_lw = 1'b0;
    p_code = QUESTION_CODE;
    if (b_q == 8'h00) begin
      p_pre = lead_waiting;
    end else if (lead_waiting && is_trail(b_q)) begin
      p_act = 1'b1;
      p_pair = 1'b1;
      p_code = jis_code(pending_lead, b_q);
    end else begin
      p_pre = lead_waiting;
      if (is_lead(b_q)) begin
        p_act = last_q;
        p_lw = !last_q;
      end else begin
        p_act = 1'b1;
        if (b_q < 8'h80 || (b_q >= 8'ha1 && b_q <= 8'hdf)) p_code = {8'h00, b_q};
      end
    end
  end

  always_comb begin
    sts.op = op_q;
    sts.pre_q = pre_q;
    sts.main_act = main_act;
    sts.emit_pair = emit_pair;
    sts.emit_lf = !emit_pair && emit_code == {8'h00, CH_LF};
    sts.emit_cr = !emit_pair && emit_code == {8'h00, CH_CR};
    sts.emit_bs = !emit_pair && emit_code == {8'h00, CH_BS};
    sts.col_zero = (cur_col == 7'd0);
    sts.wrap = emit_pair ? ({1'b0, cur_col} + 8'd1 >= {1'b0, COLS7}) : (cur_col >= COLS7);
    sts.row_last = ({1'b0, cur_row} + 6'd1 >= {1'b0, ROWS5});
    sts.cnt_copy_last = (cnt == COPY_LAST);
    sts.cnt_fill_last = (cnt == FILL_LAST);
    sts.out_free = !out_valid || out_ready;
  end

  always_comb begin
    we = 1'b0;
    waddr = cur_addr;
    wdata = {normal_attribute, emit_code};
    if (cp_v) begin
      we = 1'b1;
      waddr = cp_addr;
      wdata = rdata;
    end else if (cmd.fill) begin
      we = 1'b1;
      waddr = cnt;
      wdata = {normal_attribute, SPACE_CODE};
    end else if (cmd.bs) begin
      we = 1'b1;
      waddr = cur_addr - AW'(1);
      wdata = {normal_attribute, SPACE_CODE};
    end else if (cmd.write1) begin
      we = 1'b1;
    end else if (cmd.write2) begin
      we = 1'b1;
      wdata = {normal_attribute, emit_code | SECOND_HALF};
    end
    re = cmd.scroll_rd || (cmd.rd_cell && in_range);
    raddr = cmd.scroll_rd ? cnt + COLS_A : cell_addr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= op;
      b_q <= byte_in;
      last_q <= end_of_string;
      r_q <= row;
      c_q <= column;
    end
    if (cmd.plan) begin
      main_act <= p_act;
      main_pair <= p_pair;
      main_code <= p_code;
      pending_lead <= b_q;
    end
    if (cmd.load_q) begin
      emit_code <= QUESTION_CODE;
      emit_pair <= 1'b0;
    end else if (cmd.load_main) begin
      emit_code <= main_code;
      emit_pair <= main_pair;
    end
    cp_addr <= cnt;
    if (cmd.out_load) begin
      read_code <= (op_q == OP_READ && ok_q) ? rdata[15:0] : 16'd0;
      read_attribute <= (op_q == OP_READ && ok_q) ? rdata[23:16] : 8'd0;
      row_now <= cur_row;
      column_now <= cur_col;
      accepted <= ok_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      lead_waiting <= 1'b0;
      pre_q <= 1'b0;
      cnt <= '0;
      cp_v <= 1'b0;
      ok_q <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      cp_v <= cmd.scroll_rd;
      if (cmd.latch) ok_q <= 1'b1;
      if (cmd.plan) begin
        pre_q <= p_pre;
        lead_waiting <= p_lw;
      end
      if (cmd.drop_lead) lead_waiting <= 1'b0;
      if (cmd.setcur || cmd.rd_cell) ok_q <= in_range;
      if (cmd.setcur && in_range) begin
        cur_row <= r_q;
        cur_col <= c_q;
        lead_waiting <= 1'b0;
      end
      if (cmd.col0) cur_col <= '0;
      if (cmd.bs || (cmd.col0 && 1'b0)) cur_col <= cur_col - 7'd1;
      if (cmd.write1 || cmd.write2) cur_col <= cur_col + 7'd1;
      if (cmd.newline) begin
        cur_col <= '0;
        if (!sts.row_last) cur_row <= cur_row + 5'd1;
      end
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_lastrow) cnt <= COPY_A;
      else if (cmd.scroll_rd || cmd.fill) cnt <= sts.cnt_fill_last ? '0 : cnt + AW'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
